[design/masked_byte_pattern_search_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the masked byte pattern search unit
// Clocked property checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef MASKED_BYTE_PATTERN_SEARCH_UNIT_ASSERT_SVH
`define MASKED_BYTE_PATTERN_SEARCH_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// checked only out of reset
`define MBPS_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("mbps assertion failed");

// checked at every edge, reset included
`define MBPS_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("mbps assertion failed");

`else

`define MBPS_ASSERT(label, clk, rst_n, prop)
`define MBPS_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

[design/mbps_pkg.sv]
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared constants, types and helpers of the masked byte pattern search unit.
// ----------------------------------------------------------------------------
package mbps_pkg;

	localparam int MAX_SIGNATURE = 16;
	localparam int OFFSET_BITS   = 32;
	localparam int BYTE_W        = 8;
	localparam int LEN_W         = 5;
	localparam int WIN_IDX_W     = (MAX_SIGNATURE > 1) ? $clog2(MAX_SIGNATURE) : 1;
	localparam int CFG_DATA_W    = 64;
	localparam int CFG_INDEX_W   = 2;
	localparam int CARE_W        = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_SIG_LOW  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SIG_HIGH = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_CARE     = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_LENGTH   = 2'd3;

	localparam logic [CARE_W-1:0] CARE_RESET   = '1;
	localparam logic [LEN_W-1:0]  LENGTH_RESET = 5'd1;

	typedef logic [BYTE_W-1:0]      byte_t;
	typedef logic [OFFSET_BITS-1:0] offset_t;
	typedef byte_t [MAX_SIGNATURE-1:0] window_t;

	localparam offset_t COUNT_MAX = '1;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] sig_low;
		logic [CFG_DATA_W-1:0] sig_high;
		logic [CARE_W-1:0]     care;
		logic [LEN_W-1:0]      length;
	} cfg_t;

	typedef struct packed {
		logic    hit;
		offset_t offset;
	} match_t;

	function automatic logic [LEN_W-1:0] clamp_length(input logic [LEN_W-1:0] len);
		logic [LEN_W-1:0] res;
		res = len;
		if (res == '0)
			res = LEN_W'(1);
		if (res > LEN_W'(MAX_SIGNATURE))
			res = LEN_W'(MAX_SIGNATURE);
		return res;
	endfunction

endpackage

[design/mbps_if.sv]
// ----------------------------------------------------------------------------
// mbps channel interfaces
// Valid/ready channels for byte input and search results.
// ----------------------------------------------------------------------------
interface mbps_in_if;
	logic              valid;
	logic              ready;
	mbps_pkg::byte_t   data_byte;
	logic              end_of_region;

	modport source (output valid, output data_byte, output end_of_region, input ready);
	modport sink   (input valid, input data_byte, input end_of_region, output ready);
endinterface

interface mbps_out_if;
	logic              valid;
	logic              ready;
	logic              found;
	mbps_pkg::offset_t match_offset;

	modport source (output valid, output found, output match_offset, input ready);
	modport sink   (input valid, input found, input match_offset, output ready);
endinterface

[design/mbps_cfg.sv]
// ----------------------------------------------------------------------------
// mbps_cfg
// Configuration register file: signature, care mask and signature length.
// ----------------------------------------------------------------------------
module mbps_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mbps_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [mbps_pkg::CFG_DATA_W-1:0]     cfg_data,
	output mbps_pkg::cfg_t                      cfg
);

	mbps_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sig_low  <= '0;
			cfg_q.sig_high <= '0;
			cfg_q.care     <= mbps_pkg::CARE_RESET;
			cfg_q.length   <= mbps_pkg::LENGTH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				mbps_pkg::REG_SIG_LOW: begin
					cfg_q.sig_low <= cfg_data;
				end
				mbps_pkg::REG_SIG_HIGH: begin
					cfg_q.sig_high <= cfg_data;
				end
				mbps_pkg::REG_CARE: begin
					cfg_q.care <= cfg_data[mbps_pkg::CARE_W-1:0];
				end
				mbps_pkg::REG_LENGTH: begin
					cfg_q.length <= cfg_data[mbps_pkg::LEN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[design/mbps_match.sv]
// ----------------------------------------------------------------------------
// mbps_match
// Masked compare of the updated byte window against the signature.
// ----------------------------------------------------------------------------
module mbps_match (
	input  mbps_pkg::cfg_t    cfg,
	input  mbps_pkg::window_t window,
	input  mbps_pkg::offset_t count,
	output mbps_pkg::match_t  result
);

	logic [mbps_pkg::LEN_W-1:0]  len;
	logic [mbps_pkg::LEN_W-1:0]  pos;
	logic [2*mbps_pkg::CFG_DATA_W-1:0] sig;
	logic                        miss;
	mbps_pkg::offset_t           len_ext;

	always_comb begin
		len     = mbps_pkg::clamp_length(cfg.length);
		len_ext = mbps_pkg::OFFSET_BITS'(len);
		sig     = {cfg.sig_high, cfg.sig_low};
		miss    = 1'b0;
		pos     = '0;
		// signature byte k lines up with window entry len-1-k (entry 0 newest)
		for (int k = 0; k < mbps_pkg::MAX_SIGNATURE; k++) begin
			pos = len - mbps_pkg::LEN_W'(k) - mbps_pkg::LEN_W'(1);
			if ((mbps_pkg::LEN_W'(k) < len) && cfg.care[k] &&
				(window[pos[mbps_pkg::WIN_IDX_W-1:0]] != sig[k*mbps_pkg::BYTE_W +: mbps_pkg::BYTE_W]))
				miss = 1'b1;
		end
		result.hit    = (count >= len_ext) && !miss;
		result.offset = count - len_ext;
	end

endmodule

[design/masked_byte_pattern_search_unit.sv]
// ----------------------------------------------------------------------------
// masked_byte_pattern_search_unit
// Scans a byte stream for a wildcard signature; one result per match or
// per unmatched region.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                         | transaction
//  ---------+-----+---------------------------------+---------------------------
//  in_ch    | in  | data_byte, end_of_region        | one region byte
//  out_ch   | out | found, match_offset             | zero or one per byte
//  cfg_*    | in  | cfg_index, cfg_data             | one register write
//
//  One byte per cycle sustained while no result is stalled; a byte passes the
//  input register, then the window update plus masked compare into the result
//  register. Reset clears the window, byte count, match flag and loads the
//  register defaults. A stalled result holds the pipe; the input register
//  still takes one byte while the result waits.
// ----------------------------------------------------------------------------
`include "masked_byte_pattern_search_unit_assert.svh"

module masked_byte_pattern_search_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	mbps_in_if.sink                          in_ch,
	mbps_out_if.source                       out_ch,
	input  logic                             cfg_we,
	input  logic [mbps_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [mbps_pkg::CFG_DATA_W-1:0]  cfg_data
);

	mbps_pkg::cfg_t    cfg;
	mbps_pkg::match_t  match;

	logic              valid_s1;
	mbps_pkg::byte_t   data_s1;
	logic              eor_s1;

	mbps_pkg::window_t window_q;
	mbps_pkg::window_t win_next;
	mbps_pkg::offset_t count_q;
	mbps_pkg::offset_t count_next;
	logic              reported_q;

	logic              out_valid_q;
	logic              found_q;
	mbps_pkg::offset_t offset_q;

	logic              accept;
	logic              advance;
	logic              emit;

	mbps_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	always_comb begin
		win_next[0] = data_s1;
		for (int i = 1; i < mbps_pkg::MAX_SIGNATURE; i++)
			win_next[i] = window_q[i-1];
		count_next = (count_q == mbps_pkg::COUNT_MAX) ? count_q : count_q + 1'b1;
	end

	mbps_match u_match (
		.cfg    (cfg),
		.window (win_next),
		.count  (count_next),
		.result (match)
	);

	assign advance      = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || advance;
	assign accept       = in_ch.valid && in_ch.ready;
	assign emit         = !reported_q && (match.hit || eor_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= in_ch.data_byte;
			eor_s1  <= in_ch.end_of_region;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q   <= '0;
			count_q    <= '0;
			reported_q <= 1'b0;
		end else if (advance) begin
			if (eor_s1) begin
				window_q   <= '0;
				count_q    <= '0;
				reported_q <= 1'b0;
			end else if (!reported_q) begin
				window_q <= win_next;
				count_q  <= count_next;
				if (match.hit)
					reported_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			found_q  <= match.hit;
			offset_q <= match.hit ? match.offset : '0;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.found        = found_q;
	assign out_ch.match_offset = offset_q;

	`MBPS_ASSERT(a_no_emit_after_report, clk, arst_n, (advance && reported_q) |-> !emit)
	`MBPS_ASSERT(a_miss_only_at_end, clk, arst_n, (advance && emit && !match.hit) |-> eor_s1)
	`MBPS_ASSERT(a_rearm_at_end, clk, arst_n, (advance && eor_s1) |=> (!reported_q && (count_q == '0)))
	`MBPS_ASSERT(a_hit_sets_flag, clk, arst_n, (advance && emit && match.hit && !eor_s1) |=> reported_q)
	`MBPS_ASSERT_ALWAYS(a_quiet_in_reset, clk, !arst_n |=> (!out_valid_q && !valid_s1))

endmodule
